[sv/hcbp_pkg.sv]
// Shared types, codes and constants for the code bit packer.
package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int ALPHABET     = 256;
    localparam int WORD_BITS    = 32;
    localparam int LEN_W        = 6;
    localparam int ACC_W        = 40;

    // Longest length a table entry may hold.
    localparam int LEN_CAP = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic tbl_write;
        logic merge;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic has_bytes;
        logic last_byte;
        logic out_free;
    } status_t;

endpackage

[sv/hcbp_table.sv]
// Code table memory with per-entry valid bits and a registered read port.
module hcbp_table #(
    parameter int ALPHABET = hcbp_pkg::ALPHABET
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          rd_en,
    input  logic [7:0]                    symbol,
    input  logic [hcbp_pkg::WORD_BITS-1:0] wr_word,
    input  logic [hcbp_pkg::LEN_W-1:0]     wr_len,
    output logic [hcbp_pkg::WORD_BITS-1:0] rd_word,
    output logic [hcbp_pkg::LEN_W-1:0]     rd_len
);

    localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int ENTRY_W = hcbp_pkg::WORD_BITS + hcbp_pkg::LEN_W;

    logic [ENTRY_W-1:0]              mem [ALPHABET];
    logic [ALPHABET-1:0]             valid_reg;
    logic [ENTRY_W-1:0]              rd_data_reg;
    logic                            rd_ok_reg;
    logic [AW-1:0]                   addr;
    logic                            sym_ok;
    logic [hcbp_pkg::LEN_W-1:0]      len_capped;

    assign addr   = symbol[AW-1:0];
    assign sym_ok = ({1'b0, symbol} < 9'(ALPHABET));

    assign len_capped = (wr_len > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP)) ?
                        hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP) : wr_len;

    always_ff @(posedge clk)
    begin
        if (wr_en && sym_ok)
        begin
            mem[addr] <= {len_capped, wr_word};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && sym_ok)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= sym_ok && valid_reg[addr];
            end
        end
    end

    // Unwritten or out-of-range entries read as zero length.
    assign rd_word = rd_data_reg[hcbp_pkg::WORD_BITS-1:0];
    assign rd_len  = rd_ok_reg ? rd_data_reg[ENTRY_W-1:hcbp_pkg::WORD_BITS] : '0;

endmodule

[sv/hcbp_datapath.sv]
// Bit accumulator, pending byte state and output register.
module hcbp_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hcbp_pkg::cmd_t                cmd,
    input  logic [1:0]                    mode,
    input  logic [hcbp_pkg::WORD_BITS-1:0] rd_word,
    input  logic [hcbp_pkg::LEN_W-1:0]     rd_len,
    input  logic                          m_tready,
    output hcbp_pkg::status_t             status,
    output logic [7:0]                    out_byte,
    output logic                          out_last,
    output logic                          out_valid
);

    localparam int ACC_W = hcbp_pkg::ACC_W;
    localparam int LEN_W = hcbp_pkg::LEN_W;
    localparam int WB    = hcbp_pkg::WORD_BITS;

    logic             flush_reg, flush_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [2:0]       nb_reg, nb_next;
    logic [7:0]       pend_bits_reg, pend_bits_next;
    logic [2:0]       pend_cnt_reg, pend_cnt_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             out_valid_reg, out_valid_next;

    logic [WB:0]      mask;
    logic [WB-1:0]    masked;
    logic [LEN_W-1:0] total;
    logic [LEN_W-1:0] sh;
    logic [ACC_W-1:0] merged;
    logic [2:0]       merged_nb;

    always_comb
    begin
        mask   = (33'd1 << rd_len) - 33'd1;
        masked = rd_word & mask[WB-1:0];
        if (flush_reg)
        begin
            total = (pend_cnt_reg != 3'd0) ? LEN_W'(8) : '0;
        end
        else
        begin
            total = LEN_W'(pend_cnt_reg) + rd_len;
        end
        // Place the code right behind the pending bits, MSB first.
        sh     = LEN_W'(ACC_W) - total;
        merged = {pend_bits_reg, {(ACC_W-8){1'b0}}};
        if (!flush_reg)
        begin
            merged = merged | (ACC_W'({8'b0, masked}) << sh);
        end
        merged_nb = total[5:3];
    end

    always_comb
    begin
        flush_next     = flush_reg;
        acc_next       = acc_reg;
        nb_next        = nb_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;

        if (cmd.capture)
        begin
            flush_next = (mode == hcbp_pkg::MODE_FLUSH);
        end

        if (cmd.merge)
        begin
            acc_next      = merged;
            nb_next       = merged_nb;
            pend_cnt_next = total[2:0];
            unique case (merged_nb)
                3'd0:    pend_bits_next = merged[39:32];
                3'd1:    pend_bits_next = merged[31:24];
                3'd2:    pend_bits_next = merged[23:16];
                3'd3:    pend_bits_next = merged[15:8];
                default: pend_bits_next = merged[7:0];
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            out_byte_next  = acc_reg[ACC_W-1 -: 8];
            out_last_next  = (nb_reg == 3'd1);
            out_valid_next = 1'b1;
            acc_next       = acc_reg << 8;
            nb_next        = nb_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_reg     <= 1'b0;
            nb_reg        <= '0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            flush_reg     <= flush_next;
            nb_reg        <= nb_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign status.has_bytes = (nb_reg != 3'd0);
    assign status.last_byte = (nb_reg == 3'd1);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

endmodule

[sv/hcbp_ctrl.sv]
// Controller state machine: accept, merge, then emit bytes one per cycle unless the output stalls.
module hcbp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic [1:0]        mode,
    input  hcbp_pkg::status_t status,
    output logic              s_tready,
    output hcbp_pkg::cmd_t    cmd
);

    hcbp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcbp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;

        unique case (state_reg)
            hcbp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (mode)
                        hcbp_pkg::MODE_LOAD:
                        begin
                            cmd.tbl_write = 1'b1;
                        end
                        hcbp_pkg::MODE_ENCODE, hcbp_pkg::MODE_FLUSH:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = hcbp_pkg::ST_MERGE;
                        end
                        default:
                        begin
                            // drop unused mode
                        end
                    endcase
                end
            end
            hcbp_pkg::ST_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = hcbp_pkg::ST_EMIT;
            end
            hcbp_pkg::ST_EMIT:
            begin
                if (!status.has_bytes)
                begin
                    state_next = hcbp_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_byte)
                    begin
                        state_next = hcbp_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = hcbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/huffman_code_bit_packer_top.sv]
// An encode or flush item passes through the table read, the merge step and the output
// register before its first byte shows; it makes up to 4 output bytes, one per cycle
// unless the output stalls, and no new item is taken until its last byte is in the output
// register. Load and unused-mode items finish on acceptance, so the next may follow at once.
// Reset: table valid bits, pending bits and the output valid flag clear at once;
// every table entry reads as zero length until loaded, with no clearing pass.
module huffman_code_bit_packer_top #(
    parameter int ALPHABET = hcbp_pkg::ALPHABET
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // symbol[7:0], code_word[39:8], code_length[45:40], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast
);

    hcbp_pkg::cmd_t    cmd;
    hcbp_pkg::status_t status;
    logic [hcbp_pkg::WORD_BITS-1:0] rd_word;
    logic [hcbp_pkg::LEN_W-1:0]     rd_len;

    hcbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    hcbp_table #(
        .ALPHABET (ALPHABET)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd.tbl_write),
        .rd_en   (cmd.capture),
        .symbol  (s_tdata[7:0]),
        .wr_word (s_tdata[39:8]),
        .wr_len  (s_tdata[45:40]),
        .rd_word (rd_word),
        .rd_len  (rd_len)
    );

    hcbp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mode      (s_tuser),
        .rd_word   (rd_word),
        .rd_len    (rd_len),
        .m_tready  (m_tready),
        .status    (status),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_valid (m_tvalid)
    );

endmodule

[sv/hcbp_checker.sv]
// Port-level checker for the code bit packer, bound to the top level.
module hcbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // A stalled output item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // Encode and flush items keep the block busy through lookup and merge.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready &&
        (s_tuser == hcbp_pkg::MODE_ENCODE || s_tuser == hcbp_pkg::MODE_FLUSH)
        |=> !s_tready ##1 !s_tready)
        else $error("input taken during encode or flush");

    // A table load leaves the input ready in the next cycle.
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == hcbp_pkg::MODE_LOAD |=> s_tready)
        else $error("load item stalled the input");

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_hcbp_checker (.*);

[bench/testbench.sv]
// Testbench for the code bit packer: table loads, MSB-first encode, flush and output order.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int NO_PROGRESS_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } packed_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // symbol[7:0], code_word[39:8], code_length[45:40], zero pad
    logic [1:0]  s_tuser;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte[7:0]
    logic        m_tlast;

    // Shadow copy of the code table and the partial byte.
    logic [31:0]  shadow_word [hcbp_pkg::ALPHABET];
    logic [5:0]   shadow_len [hcbp_pkg::ALPHABET];
    logic [7:0]   shadow_pending;
    int           shadow_count;
    packed_byte_t expected_bytes[$];

    int  mismatches;
    int  idle_cycles;
    int  rx_hold;
    bit  tx_steady;
    bit  rx_steady;
    int  symbol_pool[16];

    huffman_code_bit_packer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [5:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 6'd0;
        else if (r < 60)
            return 6'($urandom_range(1, 8));
        else if (r < 85)
            return 6'($urandom_range(9, 20));
        else if (r < 95)
            return 6'($urandom_range(21, 32));
        else
            return 6'($urandom_range(33, 63));
    endfunction

    // Advance the shadow state by one accepted item and queue the bytes it makes.
    task automatic predict_item(input logic [1:0] mode, input logic [7:0] sym,
                                input logic [31:0] word, input logic [5:0] len);
        packed_byte_t made[$];
        packed_byte_t pb;
        int           n_bits;
        case (mode)
            hcbp_pkg::MODE_LOAD:
            begin
                shadow_word[sym] = word;
                shadow_len[sym]  = (len > hcbp_pkg::LEN_CAP) ? 6'(hcbp_pkg::LEN_CAP) : len;
            end
            hcbp_pkg::MODE_ENCODE:
            begin
                n_bits = shadow_len[sym];
                for (int j = n_bits - 1; j >= 0; j--)
                begin
                    shadow_pending[7 - shadow_count] = shadow_word[sym][j];
                    shadow_count++;
                    if (shadow_count == 8)
                    begin
                        pb.out_byte = shadow_pending;
                        pb.last     = 1'b0;
                        made.push_back(pb);
                        shadow_pending = '0;
                        shadow_count   = 0;
                    end
                end
                if (made.size() > 0)
                    made[made.size() - 1].last = 1'b1;
                foreach (made[i])
                    expected_bytes.push_back(made[i]);
            end
            hcbp_pkg::MODE_FLUSH:
            begin
                if (shadow_count != 0)
                begin
                    pb.out_byte = shadow_pending;
                    pb.last     = 1'b1;
                    expected_bytes.push_back(pb);
                end
                shadow_pending = '0;
                shadow_count   = 0;
            end
            default: ;
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [1:0] mode, input logic [7:0] sym,
                             input logic [31:0] word, input logic [5:0] len);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, len, word, sym};
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(mode, sym, word, len);
        @(negedge clk);
    endtask

    // Encode before any load, flush with nothing pending, unused mode.
    task automatic test_empty_table();
        send_item(hcbp_pkg::MODE_ENCODE, 8'd0, 32'hFFFF_FFFF, 6'd63);
        send_item(hcbp_pkg::MODE_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'd32);
        send_item(hcbp_pkg::MODE_FLUSH, 8'd0, 32'd0, 6'd0);
        send_item(MODE_UNUSED, 8'd17, 32'h1234_5678, 6'd12);
    endtask

    task automatic test_load_extremes();
        send_item(hcbp_pkg::MODE_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
        // overlong lengths clamp to 32
        send_item(hcbp_pkg::MODE_LOAD, 8'd255, 32'h0000_0000, 6'd63);
        send_item(hcbp_pkg::MODE_LOAD, 8'd1, 32'h0000_00A5, 6'd8);
        // bits above the length stay in the table but never reach the output
        send_item(hcbp_pkg::MODE_LOAD, 8'd2, 32'hFFFF_FFF5, 6'd3);
        send_item(hcbp_pkg::MODE_LOAD, 8'd3, 32'hFFFF_FFFF, 6'd0);
        send_item(hcbp_pkg::MODE_LOAD, 8'd4, 32'h0000_0001, 6'd1);
        send_item(hcbp_pkg::MODE_LOAD, 8'd5, 32'h8000_0001, 6'd33);
    endtask

    task automatic test_encode_cases();
        send_item(hcbp_pkg::MODE_ENCODE, 8'd1, 32'd0, 6'd0);
        send_item(hcbp_pkg::MODE_ENCODE, 8'd2, 32'd0, 6'd0);
        send_item(hcbp_pkg::MODE_ENCODE, 8'd0, 32'd0, 6'd0);
        send_item(hcbp_pkg::MODE_ENCODE, 8'd255, 32'd0, 6'd0);
        send_item(hcbp_pkg::MODE_ENCODE, 8'd3, 32'd0, 6'd0);
        send_item(hcbp_pkg::MODE_ENCODE, 8'd4, 32'd0, 6'd0);
        send_item(hcbp_pkg::MODE_FLUSH, 8'd0, 32'd0, 6'd0);
        send_item(hcbp_pkg::MODE_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        send_item(MODE_UNUSED, 8'd0, 32'hFFFF_FFFF, 6'd63);
        send_item(hcbp_pkg::MODE_ENCODE, 8'd5, 32'd0, 6'd0);
        send_item(hcbp_pkg::MODE_ENCODE, 8'd4, 32'd0, 6'd0);
        send_item(hcbp_pkg::MODE_FLUSH, 8'd0, 32'd0, 6'd0);
    endtask

    // Mostly encodes, with some loads, flushes and unused-mode items, over a small working set.
    task automatic test_random_stream(input int count, input bit steady);
        int         done;
        int         r;
        int         slot;
        logic [7:0] sym;
        tx_steady = steady;
        rx_steady = steady;
        done = 0;
        while (done < count)
        begin
            r    = $urandom_range(0, 99);
            slot = $urandom_range(0, 15);
            sym  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(symbol_pool[slot]);
            if ($urandom_range(0, 49) == 0)
                symbol_pool[slot] = $urandom_range(0, 255);
            if (r < 20)
                send_item(hcbp_pkg::MODE_LOAD, sym, $urandom, pick_length());
            else if (r < 85)
                send_item(hcbp_pkg::MODE_ENCODE, sym, $urandom, 6'($urandom));
            else if (r < 96)
                send_item(hcbp_pkg::MODE_FLUSH, sym, $urandom, 6'($urandom));
            else
                send_item(MODE_UNUSED, sym, $urandom, 6'($urandom));
            done++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = hcbp_pkg::MODE_LOAD;
        mismatches     = 0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        shadow_pending = '0;
        shadow_count   = 0;
        for (int i = 0; i < hcbp_pkg::ALPHABET; i++)
        begin
            shadow_word[i] = '0;
            shadow_len[i]  = '0;
        end
        for (int i = 0; i < 16; i++)
            symbol_pool[i] = $urandom_range(0, 255);
        symbol_pool[0] = 0;
        symbol_pool[1] = 255;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_table();
        test_load_extremes();
        test_encode_cases();
        test_random_stream(250, 1'b0);
        test_random_stream(40, 1'b1);

        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Output side: random stalls, or always ready in steady phases.
    initial
    begin
        m_tready = 1'b0;
        rx_hold  = 0;
        forever
        begin
            @(negedge clk);
            if (rx_steady)
                m_tready <= 1'b1;
            else if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                rx_hold = pick_gap();
                m_tready <= (rx_hold == 0);
                if (rx_hold > 0)
                    rx_hold--;
            end
        end
    end

    always @(posedge clk)
    begin
        packed_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected item: got byte %02h last %0b, expected none",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.out_byte)
                begin
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, want.out_byte, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Stop the run when neither side makes progress for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= NO_PROGRESS_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d bytes outstanding",
                     $time, idle_cycles, expected_bytes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule

[sim.f]
sv/hcbp_pkg.sv
sv/hcbp_table.sv
sv/hcbp_datapath.sv
sv/hcbp_ctrl.sv
sv/huffman_code_bit_packer_top.sv
sv/hcbp_checker.sv
bench/testbench.sv
